// ===== rtl/ufq_pkg.sv =====
// shared types and constants for the unique identifier queue
package ufq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF = 32;
  localparam int FIELD_ID_W   = 32;
  localparam int FIELD_CNT_W  = 5;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } ufq_status_e;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_SERVE  = 1'b1
  } ufq_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_APPEND,
    S_HEAD,
    S_FINISH
  } ufq_state_t;

  typedef struct packed {
    logic                   command;
    logic signed [FIELD_ID_W-1:0] id;
  } ufq_req_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [FIELD_ID_W-1:0] served_id;
    logic                         head_valid;
    logic signed [FIELD_ID_W-1:0] head_id;
    logic [FIELD_CNT_W-1:0]       count;
  } ufq_rsp_t;

  typedef struct packed {
    logic        accept;
    logic        scan_start;
    logic        scan_step;
    logic        append;
    logic        pop;
    logic        head_load;
    logic        status_load;
    ufq_status_e status_code;
    logic        out_load;
  } ufq_cmd_t;

  typedef struct packed {
    logic is_serve;
    logic empty;
    logic full;
    logic scan_done;
    logic match;
    logic out_free;
  } ufq_flags_t;

endpackage

// ===== rtl/unique_id_fifo_queue.sv =====
// top level of the first-in first-out queue of unique identifiers
//
//   channel  handshake              payload
//   req      req_valid / req_stall  req: command, id
//   rsp      rsp_valid / rsp_stall  rsp: status, served_id, head_valid, head_id, count
//
// how long an insert takes is set by the duplicate scan, which reads one ring entry per
// cycle through the single read port; a duplicate ends the scan early, and an insert
// refused as full skips the append step; a serve on an empty queue skips the head load step
// synchronous reset empties the ring; entries are never cleared
// a new request is taken while a result waits; a stalled result holds the block
// in its final step until the result register frees
module unique_id_fifo_queue #(
  parameter int DEPTH    = ufq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = ufq_pkg::ID_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ufq_pkg::ufq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ufq_pkg::ufq_rsp_t rsp
);
  import ufq_pkg::*;

  ufq_cmd_t   cmd;
  ufq_flags_t flags;

  ufq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .flags     (flags),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  ufq_dp #(
    .DEPTH    (DEPTH),
    .ID_WIDTH (ID_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .flags     (flags),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

endmodule

// ===== rtl/ufq_ctrl.sv =====
// controller state machine for the unique identifier queue
module ufq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  ufq_pkg::ufq_flags_t flags,
  output ufq_pkg::ufq_cmd_t cmd,
  output logic              req_stall
);
  import ufq_pkg::*;

  ufq_state_t state;
  ufq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = STAT_OK;
    req_stall       = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = req_valid;
        if (req_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (flags.is_serve) begin
          if (flags.empty) begin
            cmd.status_load = 1'b1;
            cmd.status_code = STAT_EMPTY;
            state_next      = S_FINISH;
          end else begin
            cmd.pop    = 1'b1;
            state_next = S_HEAD;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (flags.scan_done) begin
          if (flags.match) begin
            cmd.status_load = 1'b1;
            cmd.status_code = STAT_DUP;
            state_next      = S_FINISH;
          end else if (flags.full) begin
            cmd.status_load = 1'b1;
            cmd.status_code = STAT_FULL;
            state_next      = S_FINISH;
          end else begin
            state_next = S_APPEND;
          end
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_FINISH;
      end
      S_HEAD: begin
        cmd.head_load = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (flags.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/ufq_dp.sv =====
// datapath: entry ring, pointers, duplicate scan and result register
module ufq_dp #(
  parameter int DEPTH    = ufq_pkg::DEPTH_DEF,
  parameter int ID_WIDTH = ufq_pkg::ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ufq_pkg::ufq_req_t   req,
  input  logic                rsp_stall,
  input  ufq_pkg::ufq_cmd_t   cmd,
  output ufq_pkg::ufq_flags_t flags,
  output ufq_pkg::ufq_rsp_t   rsp,
  output logic                rsp_valid
);
  import ufq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [ID_WIDTH-1:0] store [DEPTH];
  logic [ID_WIDTH-1:0] rdata;
  logic [IW-1:0]       rd_addr;

  logic                op;
  logic [ID_WIDTH-1:0] key;
  logic [IW-1:0]       head;
  logic [IW-1:0]       tail;
  logic [CW-1:0]       count;
  logic [ID_WIDTH-1:0] head_reg;
  logic [ID_WIDTH-1:0] served;
  ufq_status_e         status_reg;

  logic [IW-1:0]       scan_ptr;
  logic [CW-1:0]       scan_left;
  logic                pend;
  logic                match_reg;
  logic                issue;
  logic                hit;

  logic [ID_WIDTH+FIELD_ID_W-1:0] id_wide;
  logic [ID_WIDTH+FIELD_ID_W-1:0] head_wide;
  logic [ID_WIDTH+FIELD_ID_W-1:0] served_wide;
  logic [CW+FIELD_CNT_W-1:0]      cnt_wide;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] pos);
    logic [IW-1:0] nxt;
    if (pos == IW'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = pos + IW'(1);
    end
    return nxt;
  endfunction

  assign id_wide = {{ID_WIDTH{1'b0}}, req.id};
  assign issue   = cmd.scan_step && (scan_left != '0) && !match_reg && !hit;
  assign hit     = pend && (rdata == key);
  assign rd_addr = cmd.pop ? ring_next(head) : scan_ptr;

  // entry ring
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      store[tail] <= key;
    end
    rdata <= store[rd_addr];
  end

  // request capture and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.append) begin
        tail  <= ring_next(tail);
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        head  <= ring_next(head);
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op         <= req.command;
      key        <= id_wide[ID_WIDTH-1:0];
      served     <= '0;
      status_reg <= STAT_OK;
    end else if (cmd.status_load) begin
      status_reg <= cmd.status_code;
    end
    if (cmd.pop) begin
      served <= head_reg;
    end
    if (cmd.append && (count == '0)) begin
      head_reg <= key;
    end else if (cmd.head_load) begin
      head_reg <= rdata;
    end
  end

  // duplicate scan, one read issued per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      match_reg <= 1'b0;
    end else if (cmd.scan_start) begin
      pend      <= 1'b0;
      match_reg <= 1'b0;
    end else if (cmd.scan_step) begin
      pend <= issue;
      if (hit) begin
        match_reg <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_ptr  <= head;
      scan_left <= count;
    end else if (issue) begin
      scan_ptr  <= ring_next(scan_ptr);
      scan_left <= scan_left - CW'(1);
    end
  end

  always_comb begin
    flags.is_serve  = (op == OP_SERVE);
    flags.empty     = (count == '0);
    flags.full      = (count >= CW'(DEPTH));
    flags.match     = hit || match_reg;
    flags.scan_done = hit || match_reg || (!pend && (scan_left == '0));
    flags.out_free  = !rsp_valid || !rsp_stall;
  end

  // result register
  assign head_wide   = {{FIELD_ID_W{1'b0}}, head_reg};
  assign served_wide = {{FIELD_ID_W{1'b0}}, served};
  assign cnt_wide    = {{FIELD_CNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status     <= status_reg;
      rsp.served_id  <= served_wide[FIELD_ID_W-1:0];
      rsp.head_valid <= (count != '0);
      rsp.head_id    <= (count != '0) ? head_wide[FIELD_ID_W-1:0] : '0;
      rsp.count      <= cnt_wide[FIELD_CNT_W-1:0];
    end
  end

endmodule

// ===== test/tb_top.sv =====
// testbench for the unique identifier queue: directed table and random requests
`timescale 1ns / 100ps

module tb_top;
  import ufq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int RAND_ITEMS = 1600;
  localparam int QUIET_TAIL = 200;
  localparam int CYCLE_MAX  = 800000;

  typedef struct {
    ufq_op_e     op;
    logic [31:0] id;
    logic        fixed;
    ufq_rsp_t    rsp;
  } dir_row_t;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  ufq_req_t  req;
  logic      rsp_valid;
  logic      rsp_stall;
  ufq_rsp_t  rsp;

  logic [31:0] ring_ids [DEPTH];
  int          ring_head;
  int          ring_tail;
  int          ring_count;

  ufq_rsp_t    pending_results[$];
  dir_row_t    dir_table[$];
  int          error_count;
  int          cycle_count;
  int          stall_left;
  logic        quiet;

  unique_id_fifo_queue uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  function automatic ufq_rsp_t queue_step(ufq_req_t r);
    ufq_rsp_t o;
    logic     found;
    int       pos;
    int       n;
    o = '0;
    found = 1'b0;
    if (r.command == OP_INSERT) begin
      pos = ring_head;
      for (n = 0; n < ring_count; n++) begin
        if (ring_ids[pos] == r.id) found = 1'b1;
        pos = (pos + 1) % DEPTH;
      end
      if (found) begin
        o.status = STAT_DUP;
      end else if (ring_count >= DEPTH) begin
        o.status = STAT_FULL;
      end else begin
        o.status = STAT_OK;
        ring_ids[ring_tail] = r.id;
        ring_tail = (ring_tail + 1) % DEPTH;
        ring_count++;
      end
    end else begin
      if (ring_count == 0) begin
        o.status = STAT_EMPTY;
      end else begin
        o.status = STAT_OK;
        o.served_id = ring_ids[ring_head];
        ring_head = (ring_head + 1) % DEPTH;
        ring_count--;
      end
    end
    o.head_valid = (ring_count != 0);
    o.head_id = (ring_count != 0) ? ring_ids[ring_head] : '0;
    o.count = ring_count[FIELD_CNT_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
    error_count++;
  endtask

  task automatic compare_result(ufq_rsp_t got, ufq_rsp_t want);
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.served_id !== want.served_id)
      report_mismatch("served_id", got.served_id, want.served_id);
    if (got.head_valid !== want.head_valid)
      report_mismatch("head_valid", 32'(got.head_valid), 32'(want.head_valid));
    if (got.head_id !== want.head_id) report_mismatch("head_id", got.head_id, want.head_id);
    if (got.count !== want.count) report_mismatch("count", 32'(got.count), 32'(want.count));
  endtask

  task automatic add_row(ufq_op_e op, logic [31:0] id, logic fixed, ufq_status_e st,
                         logic [31:0] served, logic hv, logic [31:0] hid, int cnt);
    dir_row_t row;
    row.op = op;
    row.id = id;
    row.fixed = fixed;
    row.rsp = '0;
    row.rsp.status = st;
    row.rsp.served_id = served;
    row.rsp.head_valid = hv;
    row.rsp.head_id = hid;
    row.rsp.count = cnt[FIELD_CNT_W-1:0];
    dir_table.push_back(row);
  endtask

  task automatic send_request(ufq_req_t r, logic fixed, ufq_rsp_t fixed_rsp);
    ufq_rsp_t predicted;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    predicted = queue_step(r);
    pending_results.push_back(fixed ? fixed_rsp : predicted);
  endtask

  task automatic idle_requests(int n);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    idle_requests(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("cycle %0d: request result with nothing pending", cycle_count);
        error_count++;
      end else begin
        compare_result(rsp, pending_results.pop_front());
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (rst || quiet) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(7) == 0) begin
      rsp_stall <= 1'b1;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    ufq_req_t r;
    ufq_rsp_t none;
    int       i;
    int       insert_bias;
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    quiet = 1'b0;
    error_count = 0;
    cycle_count = 0;
    stall_left = 0;
    ring_head = 0;
    ring_tail = 0;
    ring_count = 0;
    none = '0;
    insert_bias = 50;
    for (i = 0; i < DEPTH; i++) ring_ids[i] = '0;

    add_row(OP_SERVE,  32'h0,        1'b1, STAT_EMPTY, 32'h0,        1'b0, 32'h0,        0);
    add_row(OP_INSERT, 32'h7fffffff, 1'b1, STAT_OK,    32'h0,        1'b1, 32'h7fffffff, 1);
    add_row(OP_INSERT, 32'h80000000, 1'b1, STAT_OK,    32'h0,        1'b1, 32'h7fffffff, 2);
    add_row(OP_INSERT, 32'h7fffffff, 1'b1, STAT_DUP,   32'h0,        1'b1, 32'h7fffffff, 2);
    add_row(OP_INSERT, 32'h80000000, 1'b1, STAT_DUP,   32'h0,        1'b1, 32'h7fffffff, 2);
    add_row(OP_INSERT, 32'h0,        1'b0, STAT_OK,    32'h0,        1'b0, 32'h0,        0);
    add_row(OP_INSERT, 32'hffffffff, 1'b0, STAT_OK,    32'h0,        1'b0, 32'h0,        0);
    for (i = 1; i <= 12; i++) add_row(OP_INSERT, i, 1'b0, STAT_OK, 32'h0, 1'b0, 32'h0, 0);
    // full ring, then a duplicate while full
    add_row(OP_INSERT, 32'h55555555, 1'b1, STAT_FULL,  32'h0,        1'b1, 32'h7fffffff, 16);
    add_row(OP_INSERT, 32'h0,        1'b1, STAT_DUP,   32'h0,        1'b1, 32'h7fffffff, 16);
    add_row(OP_SERVE,  32'h0,        1'b1, STAT_OK,    32'h7fffffff, 1'b1, 32'h80000000, 15);
    add_row(OP_SERVE,  32'h0,        1'b0, STAT_OK,    32'h0,        1'b0, 32'h0,        0);
    add_row(OP_INSERT, 32'h7fffffff, 1'b0, STAT_OK,    32'h0,        1'b0, 32'h0,        0);
    add_row(OP_SERVE,  32'haaaaaaaa, 1'b0, STAT_OK,    32'h0,        1'b0, 32'h0,        0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[k]) begin
      r.command = dir_table[k].op;
      r.id = dir_table[k].id;
      send_request(r, dir_table[k].fixed, dir_table[k].rsp);
      if ($urandom_range(3) == 0) idle_requests($urandom_range(1, 18));
    end

    drain_results();

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 80 == 0) insert_bias = $urandom_range(15, 90);
      if (i == RAND_ITEMS / 2) drain_results();
      quiet = (i >= RAND_ITEMS - QUIET_TAIL);
      r.command = ($urandom_range(99) < insert_bias) ? OP_INSERT : OP_SERVE;
      case ($urandom_range(3))
        0: begin
          r.id = $urandom;
        end
        1: begin
          r.id = $urandom_range(31);
        end
        default: begin
          if (ring_count != 0)
            r.id = ring_ids[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
          else
            r.id = $urandom;
        end
      endcase
      send_request(r, 1'b0, none);
      if (!quiet && $urandom_range(5) == 0) idle_requests($urandom_range(1, 18));
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
